### design/sss_pkg.sv
// Shared types, constants and the quarter-wave sine table of the strafe search sequencer.
package sss_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SINE_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SINE_QAW = SINE_AW - 2;
  localparam int unsigned SINE_QDEPTH = SINE_TABLE_DEPTH / 4;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_STRAFE_DURATION   = 3'd0,
    REG_STRAFE_AMPLITUDE  = 3'd1,
    REG_FORWARD_DURATION  = 3'd2,
    REG_FORWARD_SPEED_SET = 3'd3,
    REG_SMOOTH_SPEED      = 3'd4,
    REG_INITIAL_DIRECTION = 3'd5,
    REG_PHASE_RATE        = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_SWEEP   = 2'd1,
    PH_FORWARD = 2'd2,
    PH_FINISH  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOOK,
    ST_MUL,
    ST_RND,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic [31:0] strafe_duration;
    logic [15:0] strafe_amplitude;
    logic [31:0] forward_duration;
    logic [15:0] forward_speed_set;
    logic [15:0] smooth_speed;
    logic        initial_direction;
    logic [31:0] phase_rate;
  } cfg_t;

  typedef struct packed {
    logic cap_in;
    logic ld_angle;
    logic set_start;
    logic set_dir;
    logic clr_strafe;
    logic clr_fwd;
    logic ld_smooth;
    logic ld_fwd_set;
    logic inc_pass;
    logic ld_entry;
    logic ld_prod;
    logic ld_strafe;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_active;
    logic fwd_over;
  } stat_t;

  typedef logic [14:0] sine_qtab_t [SINE_QDEPTH];

  // Sine of a quarter-turn fraction r (0 to 2^30), Q30, by a short Taylor series.
  function automatic longint unsigned quarter_sine(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [14:0] sine_mag(input longint unsigned r);
    longint unsigned m;
    m = (quarter_sine(r) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m[14:0];
  endfunction

  function automatic sine_qtab_t build_sine_qtab();
    sine_qtab_t tab;
    for (int k = 0; k < SINE_QDEPTH; k++) begin
      tab[k] = sine_mag(64'(k) << (32 - SINE_AW));
    end
    return tab;
  endfunction

  localparam sine_qtab_t SINE_QTAB = build_sine_qtab();
  localparam logic [14:0] SINE_PEAK = sine_mag(Q30_ONE);

endpackage

### design/sine_strafe_search_sequencer.sv
// Top level of the sine strafe search sequencer: register file, controller and datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_ready_o  time_now_i
//   output    out        out_valid_o/out_ready_i strafe_speed_o, forward_speed_o, pass_count_o
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// A start, forward or finish step goes from the evaluate state, which forms the angle product, to
// the done state, which loads the result register once no earlier result is pending; a sweep step
// also passes through the sine table read, amplitude multiply and rounding states in turn.
// One transaction is in work at a time; the next is accepted once the result is registered,
// even while that result still waits on out_ready_i.
// Reset puts the sequencer in the start phase with zero speeds, zero pass count and zero registers.
module sine_strafe_search_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                time_now_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         strafe_speed_o,
  output logic signed [15:0]         forward_speed_o,
  output logic [15:0]                pass_count_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sss_pkg::CFG_AW-1:0] paddr,
  input  logic [sss_pkg::CFG_DW-1:0] pwdata,
  output logic [sss_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  sss_pkg::cfg_t  cfg;
  sss_pkg::cmd_t  cmd;
  sss_pkg::stat_t stat;

  sss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sss_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .time_now_i      (time_now_i),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .strafe_speed_o  (strafe_speed_o),
    .forward_speed_o (forward_speed_o),
    .pass_count_o    (pass_count_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ld_out |-> (!out_valid_o || out_ready_i))
    else $error("Result register loaded while a result is still pending.");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !cmd.ld_out)
    else $error("Input taken or result loaded right after an accepted transaction.");

  a_pass_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pass_count_o) |-> pass_count_o == $past(pass_count_o) + 16'd1)
    else $error("Pass count moved by other than one between results.");

endmodule

### design/sss_regs.sv
// Configuration register file with its APB-style access port.
module sss_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sss_pkg::CFG_AW-1:0] paddr,
  input  logic [sss_pkg::CFG_DW-1:0] pwdata,
  output logic [sss_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output sss_pkg::cfg_t              cfg_o
);

  sss_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        sss_pkg::REG_STRAFE_DURATION:   cfg_d.strafe_duration   = pwdata;
        sss_pkg::REG_STRAFE_AMPLITUDE:  cfg_d.strafe_amplitude  = pwdata[15:0];
        sss_pkg::REG_FORWARD_DURATION:  cfg_d.forward_duration  = pwdata;
        sss_pkg::REG_FORWARD_SPEED_SET: cfg_d.forward_speed_set = pwdata[15:0];
        sss_pkg::REG_SMOOTH_SPEED:      cfg_d.smooth_speed      = pwdata[15:0];
        sss_pkg::REG_INITIAL_DIRECTION: cfg_d.initial_direction = pwdata[0];
        sss_pkg::REG_PHASE_RATE:        cfg_d.phase_rate        = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sss_pkg::REG_STRAFE_DURATION:   prdata = cfg_q.strafe_duration;
      sss_pkg::REG_STRAFE_AMPLITUDE:  prdata = {16'd0, cfg_q.strafe_amplitude};
      sss_pkg::REG_FORWARD_DURATION:  prdata = cfg_q.forward_duration;
      sss_pkg::REG_FORWARD_SPEED_SET: prdata = {16'd0, cfg_q.forward_speed_set};
      sss_pkg::REG_SMOOTH_SPEED:      prdata = {16'd0, cfg_q.smooth_speed};
      sss_pkg::REG_INITIAL_DIRECTION: prdata = {31'd0, cfg_q.initial_direction};
      sss_pkg::REG_PHASE_RATE:        prdata = cfg_q.phase_rate;
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/sss_ctrl.sv
// Controller: step state machine, sequencer phase and output valid flag.
module sss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sss_pkg::stat_t stat_i,
  output sss_pkg::cmd_t  cmd_o
);

  sss_pkg::fsm_e   state_q, state_d;
  sss_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sss_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.cap_in = in_valid_i;
        if (in_valid_i) begin
          state_d = sss_pkg::ST_EVAL;
        end
      end
      sss_pkg::ST_EVAL: begin
        cmd_o.ld_angle = 1'b1;
        state_d        = sss_pkg::ST_DONE;
        unique case (phase_q)
          sss_pkg::PH_START: begin
            cmd_o.set_start = 1'b1;
            cmd_o.set_dir   = 1'b1;
            cmd_o.clr_fwd   = 1'b1;
            phase_d         = sss_pkg::PH_SWEEP;
          end
          sss_pkg::PH_SWEEP: begin
            if (stat_i.sweep_active) begin
              cmd_o.ld_smooth = 1'b1;
              state_d         = sss_pkg::ST_LOOK;
            end else begin
              cmd_o.set_start = 1'b1;
              phase_d         = sss_pkg::PH_FORWARD;
            end
          end
          sss_pkg::PH_FORWARD: begin
            cmd_o.clr_strafe = 1'b1;
            if (stat_i.fwd_over) begin
              cmd_o.clr_fwd = 1'b1;
              phase_d       = sss_pkg::PH_FINISH;
            end else begin
              cmd_o.ld_fwd_set = 1'b1;
            end
          end
          sss_pkg::PH_FINISH: begin
            cmd_o.clr_strafe = 1'b1;
            cmd_o.clr_fwd    = 1'b1;
            cmd_o.inc_pass   = 1'b1;
            phase_d          = sss_pkg::PH_START;
          end
          default: ;
        endcase
      end
      sss_pkg::ST_LOOK: begin
        cmd_o.ld_entry = 1'b1;
        state_d        = sss_pkg::ST_MUL;
      end
      sss_pkg::ST_MUL: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = sss_pkg::ST_RND;
      end
      sss_pkg::ST_RND: begin
        cmd_o.ld_strafe = 1'b1;
        state_d         = sss_pkg::ST_DONE;
      end
      sss_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = sss_pkg::ST_IDLE;
        end
      end
      default: state_d = sss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sss_pkg::ST_IDLE;
      phase_q     <= sss_pkg::PH_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/sss_dp.sv
// Datapath: time capture, sine lookup, amplitude multiply, held speeds and output registers.
module sss_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           time_now_i,
  input  sss_pkg::cfg_t         cfg_i,
  input  sss_pkg::cmd_t         cmd_i,
  output sss_pkg::stat_t        stat_o,
  output logic signed [15:0]    strafe_speed_o,
  output logic signed [15:0]    forward_speed_o,
  output logic [15:0]           pass_count_o
);

  logic [31:0]        now_q;
  logic [31:0]        elapsed_q;
  logic [31:0]        angle_q;
  logic signed [15:0] entry_q, entry_d;
  logic signed [31:0] prod_q;
  logic [31:0]        start_q;
  logic               dir_q;
  logic [15:0]        held_strafe_q, held_strafe_d;
  logic [15:0]        held_fwd_q;
  logic [15:0]        passes_q;
  logic [15:0]        strafe_q, fwd_q, count_q;

  logic [sss_pkg::SINE_AW-1:0]  idx;
  logic [1:0]                   quad;
  logic [sss_pkg::SINE_QAW-1:0] low, low_mir;
  logic [14:0]                  mag;
  logic                         negative;
  logic signed [32:0]           rsum;
  logic signed [17:0]           rnd;

  assign stat_o.sweep_active = elapsed_q < cfg_i.strafe_duration;
  assign stat_o.fwd_over     = elapsed_q > cfg_i.forward_duration;

  assign idx      = angle_q[31 -: sss_pkg::SINE_AW];
  assign quad     = idx[sss_pkg::SINE_AW-1 -: 2];
  assign low      = idx[sss_pkg::SINE_QAW-1:0];
  assign low_mir  = sss_pkg::SINE_QAW'(0) - low;
  assign negative = quad[1] ^ dir_q;

  always_comb begin
    if (quad[0]) begin
      mag = (low == '0) ? sss_pkg::SINE_PEAK : sss_pkg::SINE_QTAB[low_mir];
    end else begin
      mag = sss_pkg::SINE_QTAB[low];
    end
    entry_d = negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    rsum = 33'(prod_q) + 33'sd16384;
    rnd  = 18'(rsum >>> 15);
    if (rnd > 18'sd32767) begin
      held_strafe_d = 16'h7fff;
    end else if (rnd < -18'sd32768) begin
      held_strafe_d = 16'h8000;
    end else begin
      held_strafe_d = rnd[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      now_q     <= time_now_i;
      elapsed_q <= time_now_i - start_q;
    end
    if (cmd_i.ld_angle) begin
      angle_q <= 32'(elapsed_q * cfg_i.phase_rate);
    end
    if (cmd_i.ld_entry) begin
      entry_q <= entry_d;
    end
    if (cmd_i.ld_prod) begin
      prod_q <= $signed(cfg_i.strafe_amplitude) * entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= '0;
      dir_q         <= 1'b0;
      held_strafe_q <= '0;
      held_fwd_q    <= '0;
      passes_q      <= '0;
      strafe_q      <= '0;
      fwd_q         <= '0;
      count_q       <= '0;
    end else begin
      if (cmd_i.set_start) begin
        start_q <= now_q;
      end
      if (cmd_i.set_dir) begin
        dir_q <= cfg_i.initial_direction ^ passes_q[0];
      end
      if (cmd_i.clr_strafe) begin
        held_strafe_q <= '0;
      end else if (cmd_i.ld_strafe) begin
        held_strafe_q <= held_strafe_d;
      end
      if (cmd_i.clr_fwd) begin
        held_fwd_q <= '0;
      end else if (cmd_i.ld_smooth) begin
        held_fwd_q <= cfg_i.smooth_speed;
      end else if (cmd_i.ld_fwd_set) begin
        held_fwd_q <= cfg_i.forward_speed_set;
      end
      if (cmd_i.inc_pass) begin
        passes_q <= passes_q + 16'd1;
      end
      if (cmd_i.ld_out) begin
        strafe_q <= held_strafe_q;
        fwd_q    <= held_fwd_q;
        count_q  <= passes_q;
      end
    end
  end

  assign strafe_speed_o  = $signed(strafe_q);
  assign forward_speed_o = $signed(fwd_q);
  assign pass_count_o    = count_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sine strafe search sequencer: directed plan, then random phases.
module tb_top;
  import sss_pkg::*;

  typedef struct packed {
    logic signed [15:0] strafe;
    logic signed [15:0] fwd;
    logic [15:0]        passes;
  } motion_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    logic        chk;
    motion_cmd_t exp_cmd;
  } plan_row_t;

  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_WRITE = 1'b1;
  localparam logic CHK_MODEL = 1'b0;
  localparam logic CHK_FIXED = 1'b1;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int RAND_PHASES = 26;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_HOLD = 300;
  localparam int GAP_MAX = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam motion_cmd_t ZERO_CMD = '0;
  localparam int PLAN_LEN = 38;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM,  REG_NONE,              32'd0,         CHK_FIXED, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd5,         CHK_FIXED, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd5,         CHK_FIXED, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd6,         CHK_FIXED, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd7,         CHK_FIXED, '{16'sh0, 16'sh0, 16'd1}},
    '{ROW_WRITE, REG_NONE,              32'hFFFF_FFFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_STRAFE_DURATION,   32'hFFFF_FFFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_STRAFE_AMPLITUDE,  32'h0000_7FFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_FORWARD_DURATION,  32'hFFFF_FFFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_FORWARD_SPEED_SET, 32'h0000_7FFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_SMOOTH_SPEED,      32'hFFFF_8000, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_PHASE_RATE,        32'h0040_0000, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd100,       CHK_FIXED, '{16'sh0, 16'sh0, 16'd1}},
    '{ROW_ITEM,  REG_NONE,              32'd100,       CHK_FIXED, '{16'sh0, 16'sh8000, 16'd1}},
    '{ROW_ITEM,  REG_NONE,              32'd356,       CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd612,       CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd868,       CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd98,        CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd99,        CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd99,        CHK_FIXED, '{16'sh0, 16'sh7FFF, 16'd1}},
    '{ROW_ITEM,  REG_NONE,              32'd98,        CHK_FIXED, '{16'sh0, 16'sh7FFF, 16'd1}},
    '{ROW_WRITE, REG_FORWARD_DURATION,  32'd0,         CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'd100,       CHK_FIXED, '{16'sh0, 16'sh0, 16'd1}},
    '{ROW_ITEM,  REG_NONE,              32'd100,       CHK_FIXED, '{16'sh0, 16'sh0, 16'd2}},
    '{ROW_WRITE, REG_STRAFE_AMPLITUDE,  32'hFFFF_8000, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_INITIAL_DIRECTION, 32'd1,         CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_PHASE_RATE,        32'hFFFF_FFFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_SMOOTH_SPEED,      32'h0000_7FFF, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_FORWARD_SPEED_SET, 32'hFFFF_8000, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'hFFFF_FFF0, CHK_FIXED, '{16'sh0, 16'sh0, 16'd2}},
    '{ROW_ITEM,  REG_NONE,              32'hFFFF_FFF5, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0010, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0300, CHK_MODEL, ZERO_CMD},
    '{ROW_WRITE, REG_STRAFE_DURATION,   32'h0000_0100, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0500, CHK_MODEL, ZERO_CMD},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0500, CHK_FIXED, '{16'sh0, 16'sh8000, 16'd2}},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0501, CHK_FIXED, '{16'sh0, 16'sh0, 16'd2}},
    '{ROW_ITEM,  REG_NONE,              32'h0000_0502, CHK_FIXED, '{16'sh0, 16'sh0, 16'd3}}
  };

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] time_now_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] strafe_speed_o;
  logic signed [15:0] forward_speed_o;
  logic [15:0] pass_count_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  logic [31:0]        cfg_strafe_dur = '0;
  logic signed [15:0] cfg_amp = '0;
  logic [31:0]        cfg_fwd_dur = '0;
  logic signed [15:0] cfg_fwd_set = '0;
  logic signed [15:0] cfg_smooth = '0;
  logic               cfg_init_dir = 1'b0;
  logic [31:0]        cfg_rate = '0;

  phase_e             seq_phase = PH_START;
  logic [31:0]        seq_t0 = '0;
  logic               seq_neg = 1'b0;
  logic signed [15:0] seq_strafe = '0;
  logic signed [15:0] seq_fwd = '0;
  logic [15:0]        seq_passes = '0;

  motion_cmd_t expected_motion [$];
  motion_cmd_t exp_now;
  int n_err = 0;
  int n_checked = 0;
  int n_items = 0;
  int n_writes = 0;
  int tx_gap_max = 0;
  int rx_stall_max = 0;
  bit rx_hold_long = 1'b0;
  bit bus_held = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sine_strafe_search_sequencer u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .time_now_i      (time_now_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .strafe_speed_o  (strafe_speed_o),
    .forward_speed_o (forward_speed_o),
    .pass_count_o    (pass_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  function automatic motion_cmd_t sequencer_step(input logic [31:0] now);
    logic [31:0]        elapsed;
    logic [31:0]        angle;
    logic [9:0]         idx;
    logic [1:0]         quad;
    longint unsigned    r, x, x2, poly, mag;
    logic signed [15:0] entry;
    longint             prod, v;
    elapsed = now - seq_t0;
    case (seq_phase)
      PH_START: begin
        seq_t0 = now;
        seq_neg = cfg_init_dir ^ seq_passes[0];
        seq_fwd = '0;
        seq_phase = PH_SWEEP;
      end
      PH_SWEEP: begin
        if (elapsed < cfg_strafe_dur) begin
          angle = elapsed * cfg_rate;
          idx = angle[31:22];
          quad = idx[9:8];
          r = 64'({idx[7:0], 22'd0});
          if (quad[0]) begin
            r = ONE_Q30 - r;
          end
          x = (r * QUARTER_TURN_Q30) >> 30;
          x2 = (x * x) >> 30;
          poly = ONE_Q30;
          poly = ONE_Q30 - ((x2 * poly) >> 30) / 72;
          poly = ONE_Q30 - ((x2 * poly) >> 30) / 42;
          poly = ONE_Q30 - ((x2 * poly) >> 30) / 20;
          poly = ONE_Q30 - ((x2 * poly) >> 30) / 6;
          mag = (((x * poly) >> 30) + 64'd16384) >> 15;
          if (mag > 64'd32767) begin
            mag = 64'd32767;
          end
          entry = mag[15:0];
          if (quad[1]) begin
            entry = -entry;
          end
          prod = longint'(cfg_amp) * longint'(entry);
          if (seq_neg) begin
            prod = -prod;
          end
          v = (prod + 64'sd16384) >>> 15;
          if (v > 32767) begin
            v = 32767;
          end
          if (v < -32768) begin
            v = -32768;
          end
          seq_strafe = v[15:0];
          seq_fwd = cfg_smooth;
        end else begin
          seq_t0 = now;
          seq_phase = PH_FORWARD;
        end
      end
      PH_FORWARD: begin
        seq_strafe = '0;
        if (elapsed > cfg_fwd_dur) begin
          seq_fwd = '0;
          seq_phase = PH_FINISH;
        end else begin
          seq_fwd = cfg_fwd_set;
        end
      end
      default: begin
        seq_strafe = '0;
        seq_fwd = '0;
        seq_passes = seq_passes + 16'd1;
        seq_phase = PH_START;
      end
    endcase
    return '{seq_strafe, seq_fwd, seq_passes};
  endfunction

  task automatic offer_time(input logic [31:0] t, input logic chk, input motion_cmd_t fixed_cmd);
    int gap;
    motion_cmd_t pred;
    if (bus_held) begin
      psel <= 1'b0;
      penable <= 1'b0;
      bus_held = 1'b0;
    end
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    time_now_i <= t;
    do @(posedge clk); while (in_ready_o !== 1'b1);
    pred = sequencer_step(t);
    expected_motion.push_back((chk == CHK_FIXED) ? fixed_cmd : pred);
    n_items++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= v;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    bus_held = 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_STRAFE_DURATION:   cfg_strafe_dur = v;
      REG_STRAFE_AMPLITUDE:  cfg_amp = v[15:0];
      REG_FORWARD_DURATION:  cfg_fwd_dur = v;
      REG_FORWARD_SPEED_SET: cfg_fwd_set = v[15:0];
      REG_SMOOTH_SPEED:      cfg_smooth = v[15:0];
      REG_INITIAL_DIRECTION: cfg_init_dir = v[0];
      REG_PHASE_RATE:        cfg_rate = v;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic check_field(input string label, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_motion.size() == 0) begin
        n_err++;
        $display("%0t: unexpected transaction, expected none, actual %h %h %h", $time,
                 strafe_speed_o, forward_speed_o, pass_count_o);
      end else begin
        exp_now = expected_motion.pop_front();
        check_field("strafe_speed", exp_now.strafe, strafe_speed_o);
        check_field("forward_speed", exp_now.fwd, forward_speed_o);
        check_field("pass_count", exp_now.passes, pass_count_o);
        n_checked++;
      end
    end
  end

  initial begin
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_long) begin
        n = LONG_HOLD;
        rx_hold_long = 1'b0;
      end else begin
        n = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    plan_row_t row;
    logic [31:0] wall, t, v, span;
    int pick, step_max;
    wall = '0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    tx_gap_max = GAP_MAX;
    rx_stall_max = GAP_MAX;
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        cfg_write(row.reg_idx, row.value);
      end else begin
        offer_time(row.value, row.chk, row.exp_cmd);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      for (int r = 0; r < 7; r++) begin
        if (ph == 0 || $urandom_range(0, 1) == 1) begin
          pick = $urandom_range(0, 19);
          v = $urandom();
          case (3'(r))
            REG_STRAFE_DURATION:
              v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 4000);
            REG_FORWARD_DURATION:
              v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 2000);
            REG_PHASE_RATE: begin
              if (pick < 10 && cfg_strafe_dur != 0 && cfg_strafe_dur != 32'hFFFF_FFFF) begin
                v = 32'((64'd1 << 32) / cfg_strafe_dur);
              end else if (pick == 10) begin
                v = 32'd0;
              end else if (pick == 11) begin
                v = 32'hFFFF_FFFF;
              end
            end
            REG_INITIAL_DIRECTION: ;
            default: begin
              if (pick == 0) begin
                v[15:0] = 16'h8000;
              end else if (pick == 1) begin
                v[15:0] = 16'h7FFF;
              end
            end
          endcase
          cfg_write(3'(r), v);
        end
      end
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      if (ph == PRESSURE_PHASE) begin
        tx_gap_max = 0;
        rx_hold_long = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        wall = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end else if (ph == 0) begin
        wall = $urandom();
      end
      span = (cfg_strafe_dur > cfg_fwd_dur) ? cfg_strafe_dur : cfg_fwd_dur;
      if (span > 20000) begin
        span = 20000;
      end
      step_max = span / 4 + 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
          wall = wall + $urandom_range(0, step_max);
          t = wall;
        end else if (pick < 19) begin
          t = $urandom();
        end else begin
          t = wall - $urandom_range(0, step_max);
        end
        offer_time(t, CHK_MODEL, ZERO_CMD);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d transactions from %0d time steps with %0d register writes,",
             n_checked, n_items, n_writes);
    $display("covering every sequencer phase over %0d completed search passes.", seq_passes);
    if (n_err == 0) begin
      $display("PASS sine_strafe_search_sequencer");
    end else begin
      $display("FAIL sine_strafe_search_sequencer");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL sine_strafe_search_sequencer");
    $finish;
  end

endmodule

### files.f
design/sss_pkg.sv
design/sss_regs.sv
design/sss_ctrl.sv
design/sss_dp.sv
design/sine_strafe_search_sequencer.sv
tb/tb_top.sv
